FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the averaged load power stepper.
// Needs nothing else; the including module supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ALP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ALP_NEVER(label, clk, rst_n, expr, msg) \
  `ALP_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

FILE: rtl/alp_pkg.sv
// Shared constants, control word types and register codes of the stepper.
// Used by the ring store, the divider, the sequencer and the top level.
package alp_pkg;

  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int N_W        = $clog2(RING_DEPTH + 1);
  localparam int LOAD_W     = 16;
  localparam int MS_W       = 16;
  localparam int ATT_W      = 7;
  localparam int WI_W       = 7;
  localparam int NUM_W      = 7;
  localparam int SUM_W      = LOAD_W + RING_AW;
  localparam int DIV_CNT_W  = $clog2(SUM_W);

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_FIELD_W = ATT_W + 1 + 1 + LOAD_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ATTEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOAD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SAMPLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS   = 3'd4;

  localparam logic [ATT_W-1:0]  MAX_ATTEN_RST   = 7'd10;
  localparam logic [ATT_W-1:0]  MIN_ATTEN_RST   = 7'd0;
  localparam logic [LOAD_W-1:0] TARGET_LOAD_RST = 16'd5000;
  localparam logic [NUM_W-1:0]  NUM_SAMPLES_RST = 7'd10;
  localparam logic [MS_W-1:0]   PERIOD_MS_RST   = 16'd6000;

  // Microprogram layout
  localparam int PROG_LEN = 12;
  localparam int PC_W     = $clog2(PROG_LEN);
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_WRITE = 4'd1;
  localparam logic [PC_W-1:0] PC_WDIV  = 4'd2;
  localparam logic [PC_W-1:0] PC_WWAIT = 4'd3;
  localparam logic [PC_W-1:0] PC_WIDX  = 4'd4;
  localparam logic [PC_W-1:0] PC_SCAN  = 4'd5;
  localparam logic [PC_W-1:0] PC_DRAIN = 4'd6;
  localparam logic [PC_W-1:0] PC_ADIV  = 4'd7;
  localparam logic [PC_W-1:0] PC_AWAIT = 4'd8;
  localparam logic [PC_W-1:0] PC_CTRL  = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd10;
  localparam logic [PC_W-1:0] PC_END   = 4'd11;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_MORE,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            take;
    logic            write;
    logic            div_start;
    logic            div_sum;
    logic            idx;
    logic            rd;
    logic            ctrl;
    logic            emit;
  } ctrl_word_t;

  typedef struct packed {
    logic in_wait;
    logic scan_more;
    logic div_busy;
    logic out_full;
  } seq_stat_t;

endpackage

FILE: rtl/averaged_load_power_stepper_core.sv
// Averaged load power stepper, top level: config registers, datapath, output stage.
// Depends on alp_pkg, alp_ring, alp_div, alp_seq and assert_macros.svh.
//
// One input beat carries a load sample and the milliseconds since the last tick; one
// output beat follows for each. The sample is written to the ring at the write index,
// the index wraps modulo the sample count (0 counts as 1), the first count entries are
// summed and floor-divided, and elapsed time piles up in a saturating counter. Once the
// counter reaches period_ms, one control step moves attenuation one dB toward more
// (mean above target) or less attenuation, clamped to [min_atten, max_atten], and the
// counter clears. A microcoded sequencer drives the work: each beat is taken, written to
// the ring, its index wrapped, the ring scanned one entry per cycle and the sum divided,
// then a control step runs and the result enters the output register, held in the emit
// step while that register is full. A shared bit-serial divider makes two passes (start,
// 23 quotient steps, handoff; index wrap, then mean). After the result is loaded the
// sequencer returns through its end step to the wait step, so beats are taken one at a
// time. The output register holds a finished result while the next beat is taken. Ring
// entries carry valid bits cleared by reset, so no clearing pass runs. Configuration
// writes are always accepted and belong only in idle periods.
`include "assert_macros.svh"

module averaged_load_power_stepper_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beat: [15:0] load_sample, [31:16] delta_ms
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [alp_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result beat: [6:0] attenuation, [7] power_written, [8] control_ran,
  // [24:9] average_load, [31:25] zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [alp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [alp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic [alp_pkg::ATT_W-1:0]  max_atten_r;
  logic [alp_pkg::ATT_W-1:0]  min_atten_r;
  logic [alp_pkg::LOAD_W-1:0] target_r;
  logic [alp_pkg::NUM_W-1:0]  num_r;
  logic [alp_pkg::MS_W-1:0]   period_r;

  // Beat and datapath state
  logic [alp_pkg::LOAD_W-1:0] sample_r;
  logic [alp_pkg::MS_W-1:0]   delta_r;
  logic [alp_pkg::N_W-1:0]    n_r;
  logic [alp_pkg::N_W-1:0]    n_eff;
  logic [alp_pkg::WI_W-1:0]   wi_r;
  logic [alp_pkg::ATT_W-1:0]  atten_r;
  logic [alp_pkg::MS_W-1:0]   elapsed_r;
  logic [alp_pkg::MS_W:0]     elapsed_sum;
  logic [alp_pkg::SUM_W-1:0]  sum_r;
  logic [alp_pkg::N_W-1:0]    scan_cnt_r;
  logic                       rd_vld_r;
  logic [alp_pkg::LOAD_W-1:0] avg_r;
  logic                       ran_r;
  logic                       pw_r;

  logic                            out_tvalid_r;
  logic [alp_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                            out_full;
  logic                            out_load;

  alp_pkg::ctrl_word_t cw;
  alp_pkg::seq_stat_t  stat;

  logic                        ring_we;
  logic [alp_pkg::LOAD_W-1:0]  ring_rdata;
  logic [alp_pkg::SUM_W-1:0]   div_dividend;
  logic                        div_busy;
  logic [alp_pkg::SUM_W-1:0]   div_quo;
  logic [alp_pkg::N_W-1:0]     div_rem;

  // Control step arithmetic
  logic                              step_up;
  logic                              at_lim;
  logic                              period_hit;
  logic signed [alp_pkg::ATT_W+1:0]  a_s;
  logic signed [alp_pkg::ATT_W+1:0]  lo_s;
  logic signed [alp_pkg::ATT_W+1:0]  hi_s;
  logic signed [alp_pkg::ATT_W+1:0]  cand;

  assign cfg_ready = 1'b1;
  assign in_tready = cw.take;

  // Zero count behaves as one; counts beyond the ring saturate at its depth.
  always_comb begin
    if (num_r == '0) begin
      n_eff = alp_pkg::N_W'(1);
    end else if (int'(num_r) > alp_pkg::RING_DEPTH) begin
      n_eff = alp_pkg::N_W'(alp_pkg::RING_DEPTH);
    end else begin
      n_eff = alp_pkg::N_W'(num_r);
    end
  end

  assign elapsed_sum = {1'b0, elapsed_r} + {1'b0, delta_r};
  assign ring_we     = cw.write && (int'(wi_r) < alp_pkg::RING_DEPTH);
  assign div_dividend = cw.div_sum ? sum_r
                                   : alp_pkg::SUM_W'(wi_r) + alp_pkg::SUM_W'(1);

  always_comb begin
    step_up    = (div_quo[alp_pkg::LOAD_W-1:0] > target_r);
    period_hit = (elapsed_r >= period_r);
    at_lim     = step_up ? (atten_r == max_atten_r) : (atten_r == min_atten_r);
    a_s        = $signed({2'b00, atten_r});
    lo_s       = $signed({2'b00, min_atten_r});
    hi_s       = $signed({2'b00, max_atten_r});
    cand       = step_up ? a_s + 9'sd1 : a_s - 9'sd1;
    // clamp low first, then high, so an inverted range lands on max_atten
    if (cand < lo_s) begin
      cand = lo_s;
    end
    if (cand > hi_s) begin
      cand = hi_s;
    end
  end

  assign out_full = out_tvalid_r && !out_tready;
  assign out_load = cw.emit && !out_full;

  always_comb begin
    stat.in_wait   = !in_tvalid;
    stat.scan_more = ({1'b0, scan_cnt_r} + 1'b1) < {1'b0, n_r};
    stat.div_busy  = div_busy;
    stat.out_full  = out_full;
  end

  alp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  alp_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ring_we),
    .waddr (alp_pkg::RING_AW'(wi_r)),
    .wdata (sample_r),
    .re    (cw.rd),
    .raddr (scan_cnt_r[alp_pkg::RING_AW-1:0]),
    .rdata (ring_rdata)
  );

  alp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cw.div_start),
    .dividend (div_dividend),
    .divisor  (n_r),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Config registers and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_atten_r  <= alp_pkg::MAX_ATTEN_RST;
      min_atten_r  <= alp_pkg::MIN_ATTEN_RST;
      target_r     <= alp_pkg::TARGET_LOAD_RST;
      num_r        <= alp_pkg::NUM_SAMPLES_RST;
      period_r     <= alp_pkg::PERIOD_MS_RST;
      wi_r         <= '0;
      atten_r      <= alp_pkg::MAX_ATTEN_RST;
      elapsed_r    <= '0;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          alp_pkg::CFG_MAX_ATTEN:   max_atten_r <= cfg_data[alp_pkg::ATT_W-1:0];
          alp_pkg::CFG_MIN_ATTEN:   min_atten_r <= cfg_data[alp_pkg::ATT_W-1:0];
          alp_pkg::CFG_TARGET_LOAD: target_r    <= cfg_data[alp_pkg::LOAD_W-1:0];
          alp_pkg::CFG_NUM_SAMPLES: num_r       <= cfg_data[alp_pkg::NUM_W-1:0];
          alp_pkg::CFG_PERIOD_MS:   period_r    <= cfg_data[alp_pkg::MS_W-1:0];
          default: ;
        endcase
      end

      rd_vld_r <= cw.rd;

      // saturate elapsed time at full scale
      if (cw.write) begin
        elapsed_r <= elapsed_sum[alp_pkg::MS_W] ? '1 : elapsed_sum[alp_pkg::MS_W-1:0];
      end

      if (cw.idx) begin
        wi_r <= alp_pkg::WI_W'(div_rem);
      end

      if (cw.ctrl && period_hit) begin
        elapsed_r <= '0;
        if (!at_lim) begin
          atten_r <= cand[alp_pkg::ATT_W-1:0];
        end
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cw.take && in_tvalid) begin
      sample_r <= in_tdata[alp_pkg::LOAD_W-1:0];
      delta_r  <= in_tdata[alp_pkg::LOAD_W +: alp_pkg::MS_W];
      n_r      <= n_eff;
    end

    // scan: clear, then accumulate each read in the cycle after it issues
    if (cw.write) begin
      sum_r      <= '0;
      scan_cnt_r <= '0;
    end else begin
      if (rd_vld_r) begin
        sum_r <= sum_r + alp_pkg::SUM_W'(ring_rdata);
      end
      if (cw.rd) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
    end

    if (cw.ctrl) begin
      avg_r <= div_quo[alp_pkg::LOAD_W-1:0];
      ran_r <= period_hit;
      pw_r  <= period_hit && !at_lim;
    end

    if (out_load) begin
      out_tdata_r <= {{alp_pkg::OUT_PAD_W{1'b0}}, avg_r, ran_r, pw_r, atten_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The divider is idle whenever a new beat may be taken.
  `ALP_NEVER(a_div_idle_at_take, clk, rst_n, in_tready && div_busy, "divider busy at take")
  // Scan reads stay within the latched sample count.
  `ALP_ASSERT(a_scan_in_range, clk, rst_n, cw.rd |-> (scan_cnt_r < n_r), "scan past count")
  // The wrapped write index lands below the sample count.
  `ALP_ASSERT(a_index_wrapped, clk, rst_n, cw.idx |=> (int'(wi_r) < int'(n_r)), "index not wrapped")
  // A new attenuation is only reported together with a control step.
  `ALP_NEVER(a_written_has_ran, clk, rst_n, out_tvalid_r && out_tdata_r[7] && !out_tdata_r[8], "write without step")

endmodule

FILE: rtl/alp_ring.sv
// Sample ring store: single write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses alp_pkg.
module alp_ring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [alp_pkg::RING_AW-1:0]   waddr,
  input  logic [alp_pkg::LOAD_W-1:0]    wdata,
  input  logic                          re,
  input  logic [alp_pkg::RING_AW-1:0]   raddr,
  output logic [alp_pkg::LOAD_W-1:0]    rdata
);

  logic [alp_pkg::LOAD_W-1:0]     mem_r [alp_pkg::RING_DEPTH];
  logic [alp_pkg::LOAD_W-1:0]     rd_r;
  logic [alp_pkg::RING_DEPTH-1:0] vld_r;
  logic                           rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rvld_r ? rd_r : '0;

endmodule

FILE: rtl/alp_div.sv
// Restoring divider, one quotient bit per cycle, shared by index wrap and mean.
// Uses alp_pkg widths.
module alp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [alp_pkg::SUM_W-1:0]   dividend,
  input  logic [alp_pkg::N_W-1:0]     divisor,
  output logic                        busy,
  output logic [alp_pkg::SUM_W-1:0]   quo,
  output logic [alp_pkg::N_W-1:0]     rem
);

  logic                          busy_r;
  logic [alp_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [alp_pkg::SUM_W-1:0]     quo_r;
  logic [alp_pkg::N_W-1:0]       rem_r;
  logic [alp_pkg::N_W-1:0]       dvs_r;
  logic [alp_pkg::N_W:0]         trial;
  logic [alp_pkg::N_W:0]         diff;
  logic                          ge;
  logic [alp_pkg::N_W-1:0]       rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[alp_pkg::SUM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[alp_pkg::N_W-1:0] : trial[alp_pkg::N_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= alp_pkg::DIV_CNT_W'(alp_pkg::SUM_W - 1);
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[alp_pkg::SUM_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/alp_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Emits one alp_pkg::ctrl_word_t per cycle; the status flags steer the jumps.
module alp_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alp_pkg::seq_stat_t   stat,
  output alp_pkg::ctrl_word_t  cw
);

  logic [alp_pkg::PC_W-1:0] pc_r;
  logic [alp_pkg::PC_W-1:0] pc_nxt;
  logic                     hit;

  function automatic alp_pkg::ctrl_word_t rom_word(input logic [alp_pkg::PC_W-1:0] pc);
    alp_pkg::ctrl_word_t w;
    w.cond      = alp_pkg::COND_NEVER;
    w.target    = alp_pkg::PC_WAIT;
    w.take      = 1'b0;
    w.write     = 1'b0;
    w.div_start = 1'b0;
    w.div_sum   = 1'b0;
    w.idx       = 1'b0;
    w.rd        = 1'b0;
    w.ctrl      = 1'b0;
    w.emit      = 1'b0;
    case (pc)
      alp_pkg::PC_WAIT: begin
        w.take   = 1'b1;
        w.cond   = alp_pkg::COND_NO_IN;
        w.target = alp_pkg::PC_WAIT;
      end
      alp_pkg::PC_WRITE: begin
        w.write = 1'b1;
      end
      alp_pkg::PC_WDIV: begin
        w.div_start = 1'b1;
      end
      alp_pkg::PC_WWAIT: begin
        w.cond   = alp_pkg::COND_DIV_BUSY;
        w.target = alp_pkg::PC_WWAIT;
      end
      alp_pkg::PC_WIDX: begin
        w.idx = 1'b1;
      end
      alp_pkg::PC_SCAN: begin
        w.rd     = 1'b1;
        w.cond   = alp_pkg::COND_MORE;
        w.target = alp_pkg::PC_SCAN;
      end
      alp_pkg::PC_DRAIN: begin
        w.cond = alp_pkg::COND_NEVER;
      end
      alp_pkg::PC_ADIV: begin
        w.div_start = 1'b1;
        w.div_sum   = 1'b1;
      end
      alp_pkg::PC_AWAIT: begin
        w.cond   = alp_pkg::COND_DIV_BUSY;
        w.target = alp_pkg::PC_AWAIT;
      end
      alp_pkg::PC_CTRL: begin
        w.ctrl = 1'b1;
      end
      alp_pkg::PC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = alp_pkg::COND_OUT_FULL;
        w.target = alp_pkg::PC_EMIT;
      end
      alp_pkg::PC_END: begin
        w.cond   = alp_pkg::COND_ALWAYS;
        w.target = alp_pkg::PC_WAIT;
      end
      default: begin
        w.cond   = alp_pkg::COND_ALWAYS;
        w.target = alp_pkg::PC_WAIT;
      end
    endcase
    return w;
  endfunction

  assign cw = rom_word(pc_r);

  always_comb begin
    case (cw.cond)
      alp_pkg::COND_NEVER:    hit = 1'b0;
      alp_pkg::COND_ALWAYS:   hit = 1'b1;
      alp_pkg::COND_NO_IN:    hit = stat.in_wait;
      alp_pkg::COND_MORE:     hit = stat.scan_more;
      alp_pkg::COND_DIV_BUSY: hit = stat.div_busy;
      alp_pkg::COND_OUT_FULL: hit = stat.out_full;
      default:                hit = 1'b0;
    endcase
    pc_nxt = hit ? cw.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= alp_pkg::PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: dv/averaged_load_power_stepper_core_test.sv
// Self-checking bench for averaged_load_power_stepper_core. It streams sample ticks,
// predicts each result beat in step with the block, and compares the beats field by field.
// Depends on alp_pkg and the stepper RTL only.
module averaged_load_power_stepper_core_test;

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int ITEM_GOAL   = 2000;
  localparam int TAIL_CYCLES = 200;
  localparam int LONG_HOLD   = 3000;
  localparam int MAX_REPORTS = 40;

  // one sample tick, laid out as in_tdata
  typedef struct packed {
    logic [alp_pkg::MS_W-1:0]   delta_ms;
    logic [alp_pkg::LOAD_W-1:0] load_sample;
  } tick_t;

  // one result beat, laid out as out_tdata
  typedef struct packed {
    logic [alp_pkg::OUT_PAD_W-1:0] pad;
    logic [alp_pkg::LOAD_W-1:0]    average_load;
    logic                          control_ran;
    logic                          power_written;
    logic [alp_pkg::ATT_W-1:0]     attenuation;
  } step_t;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_COMB} rx_mode_t;
  typedef enum logic [1:0] {LD_HIGH, LD_LOW, LD_NEAR, LD_ANY} load_bias_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // [15:0] load_sample, [31:16] delta_ms
  logic [alp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [6:0] attenuation, [7] power_written, [8] control_ran, [24:9] average_load
  logic [alp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [alp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [alp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // register shadow, as the block should see it
  logic [alp_pkg::ATT_W-1:0]  reg_max_atten   = alp_pkg::MAX_ATTEN_RST;
  logic [alp_pkg::ATT_W-1:0]  reg_min_atten   = alp_pkg::MIN_ATTEN_RST;
  logic [alp_pkg::LOAD_W-1:0] reg_target_load = alp_pkg::TARGET_LOAD_RST;
  logic [alp_pkg::NUM_W-1:0]  reg_num_samples = alp_pkg::NUM_SAMPLES_RST;
  logic [alp_pkg::MS_W-1:0]   reg_period_ms   = alp_pkg::PERIOD_MS_RST;

  // stepper state mirror
  logic [alp_pkg::LOAD_W-1:0] ring_copy [alp_pkg::RING_DEPTH];
  logic [alp_pkg::WI_W-1:0]   next_slot = '0;
  logic [alp_pkg::ATT_W-1:0]  atten_now = alp_pkg::MAX_ATTEN_RST;
  logic [alp_pkg::MS_W-1:0]   elapsed_ms = '0;

  tick_t pending_ticks [$];
  step_t expected_steps [$];
  tick_t offered;
  int    ticks_added = 0;
  int    results_seen = 0;
  int    mismatches = 0;
  int    cycles = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  int    mode_left = 0;
  rx_mode_t ready_mode = RX_OPEN;
  int    hold_left = 0;
  logic  hold_done = 1'b0;

  averaged_load_power_stepper_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the mirror by one tick and return the beat the block owes for it.
  function automatic step_t predict_tick(tick_t t);
    int n;
    int i;
    int sum;
    int acc;
    int a;
    int lo;
    int hi;
    step_t r;
    r = '0;
    // a zero count averages one entry; the count can never pass the ring
    n = (reg_num_samples == 0) ? 1 : int'(reg_num_samples);
    if (n > alp_pkg::RING_DEPTH) n = alp_pkg::RING_DEPTH;
    // write at the current slot even if the count shrank below it, then wrap
    ring_copy[next_slot] = t.load_sample;
    next_slot = alp_pkg::WI_W'((int'(next_slot) + 1) % n);
    sum = 0;
    for (i = 0; i < n; i++) sum += int'(ring_copy[i]);
    r.average_load = alp_pkg::LOAD_W'(sum / n);
    // elapsed time saturates instead of wrapping
    acc = int'(elapsed_ms) + int'(t.delta_ms);
    if (acc > 65535) acc = 65535;
    if (acc >= int'(reg_period_ms)) begin
      r.control_ran = 1'b1;
      a = int'(atten_now);
      lo = int'(reg_min_atten);
      hi = int'(reg_max_atten);
      // skip the step at the limit it moves toward
      if (int'(r.average_load) > int'(reg_target_load)) begin
        if (a != hi) begin
          a++;
          r.power_written = 1'b1;
        end
      end else if (a != lo) begin
        a--;
        r.power_written = 1'b1;
      end
      // clamp low first, then high: an inverted range lands on max_atten
      if (r.power_written) begin
        if (a < lo) a = lo;
        if (a > hi) a = hi;
        atten_now = alp_pkg::ATT_W'(a);
      end
      elapsed_ms = '0;
    end else begin
      elapsed_ms = alp_pkg::MS_W'(acc);
    end
    r.attenuation = atten_now;
    return r;
  endfunction

  function automatic void note_error(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  // Sender: offer queued ticks in bursts, with random gaps between bursts.
  // Predict at acceptance so the expectation order follows the block's order.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = $urandom_range(1, 16);
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) expected_steps.push_back(predict_tick(offered));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          offered = pending_ticks.pop_front();
          in_tdata <= offered;
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 7))
              0, 1, 2, 3: gap_left = 0;
              4, 5:       gap_left = $urandom_range(1, 8);
              6:          gap_left = $urandom_range(10, 80);
              default:    gap_left = $urandom_range(100, 400);
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest expectation, then pick
  // the next ready level from a random mode that is redrawn when its run ends.
  always @(posedge clk) begin
    step_t want;
    step_t got;
    logic accept_now;
    if (!rst_n) begin
      out_tready <= 1'b0;
      mode_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = step_t'(out_tdata);
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with no tick pending, expected none, actual %h",
                     $time, out_tdata);
        end else begin
          want = expected_steps.pop_front();
          if (got.attenuation !== want.attenuation)
            note_error("attenuation", want.attenuation, got.attenuation);
          if (got.power_written !== want.power_written)
            note_error("power_written", want.power_written, got.power_written);
          if (got.control_ran !== want.control_ran)
            note_error("control_ran", want.control_ran, got.control_ran);
          if (got.average_load !== want.average_load)
            note_error("average_load", want.average_load, got.average_load);
          if (got.pad !== want.pad)
            note_error("tdata padding", want.pad, got.pad);
        end
      end
      if (mode_left <= 0) begin
        ready_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 600);
      end
      mode_left--;
      case (ready_mode)
        RX_OPEN:   accept_now = 1'b1;
        RX_HALF:   accept_now = $urandom_range(0, 1) != 0;
        RX_SPARSE: accept_now = $urandom_range(0, 4) == 0;
        default:   accept_now = (cycles % 7) < 3;
      endcase
      out_tready <= (hold_left == 0) && accept_now;
    end
  end

  // Hold the receiver off once for a long stretch while ticks are still queued,
  // so the block fills up and has to stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 300 && pending_ticks.size() > 20) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_tick(int unsigned load, int unsigned delta);
    pending_ticks.push_back('{delta_ms: alp_pkg::MS_W'(delta),
                              load_sample: alp_pkg::LOAD_W'(load)});
    ticks_added++;
  endtask

  // Block until every queued tick has produced its result beat.
  task automatic wait_drained();
    do @(posedge clk);
    while (results_seen < ticks_added);
  endtask

  task automatic write_reg(logic [alp_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= alp_pkg::CFG_DATA_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      alp_pkg::CFG_MAX_ATTEN:   reg_max_atten = alp_pkg::ATT_W'(value);
      alp_pkg::CFG_MIN_ATTEN:   reg_min_atten = alp_pkg::ATT_W'(value);
      alp_pkg::CFG_TARGET_LOAD: reg_target_load = alp_pkg::LOAD_W'(value);
      alp_pkg::CFG_NUM_SAMPLES: reg_num_samples = alp_pkg::NUM_W'(value);
      alp_pkg::CFG_PERIOD_MS:   reg_period_ms = alp_pkg::MS_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_settings(int unsigned mx, int unsigned mn, int unsigned tg,
                                int unsigned ns, int unsigned pd);
    write_reg(alp_pkg::CFG_MAX_ATTEN, mx);
    write_reg(alp_pkg::CFG_MIN_ATTEN, mn);
    write_reg(alp_pkg::CFG_TARGET_LOAD, tg);
    write_reg(alp_pkg::CFG_NUM_SAMPLES, ns);
    write_reg(alp_pkg::CFG_PERIOD_MS, pd);
  endtask

  initial begin
    int i;
    int fed;
    int phase_items;
    int seg_left;
    int load_v;
    int delta_v;
    int span;
    int mx;
    int mn;
    int tg;
    int ns;
    int pd;
    load_bias_t bias;
    for (i = 0; i < alp_pkg::RING_DEPTH; i++) ring_copy[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: full-scale and zero samples, zero and full-scale elapsed time.
    add_tick(16'hFFFF, 0);
    add_tick(16'hFFFF, 6000);
    add_tick(0, 16'hFFFF);
    wait_drained();

    // Zero period with an unreachable target: step down on every tick.
    apply_settings(10, 0, 16'hFFFF, 10, 0);
    add_tick(1234, 0);
    add_tick(16'hFFFF, 16'hFFFF);
    add_tick(16'h8000, 1);
    add_tick(0, 0);
    wait_drained();

    // Attenuation below the range: a step up clamps to min_atten.
    apply_settings(30, 20, 0, 10, 0);
    add_tick(0, 5);
    add_tick(0, 5);
    wait_drained();

    // Inverted range: min above max resolves to max_atten.
    apply_settings(25, 40, 0, 10, 0);
    add_tick(0, 5);
    wait_drained();

    // Zero sample count averages one entry.
    apply_settings(127, 0, 5000, 0, 1000);
    add_tick(777, 500);
    add_tick(999, 500);
    wait_drained();

    // Widest count, and elapsed time saturating at the longest period.
    apply_settings(127, 0, 5000, 127, 16'hFFFF);
    add_tick(16'hFFFF, 40000);
    add_tick(16'hFFFF, 40000);
    add_tick(1, 0);
    wait_drained();

    // Shrink the count below the write index: write there, then wrap.
    apply_settings(127, 0, 5000, 2, 16'hFFFF);
    add_tick(16'h4242, 16'hFFFF);
    add_tick(16'h4343, 0);
    wait_drained();

    // Random phases: new settings each phase, loads biased in runs so the
    // attenuation walks to both limits, deltas scaled to the period.
    fed = 0;
    seg_left = 0;
    bias = LD_ANY;
    while (fed < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       mx = 0;
        1:       mx = 127;
        default: mx = $urandom_range(4, 40);
      endcase
      case ($urandom_range(0, 9))
        0:       mn = 0;
        1:       mn = 127;
        2:       mn = (mx + $urandom_range(1, 5) > 127) ? 127 : mx + $urandom_range(1, 5);
        default: mn = $urandom_range(0, mx);
      endcase
      case ($urandom_range(0, 9))
        0:       tg = 0;
        1:       tg = 65535;
        default: tg = $urandom_range(1000, 60000);
      endcase
      case ($urandom_range(0, 9))
        0:       ns = 0;
        1:       ns = 127;
        2:       ns = 1;
        default: ns = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 9))
        0:       pd = 0;
        1:       pd = 65535;
        default: pd = $urandom_range(1, 3000);
      endcase
      apply_settings(mx, mn, tg, ns, pd);
      span = (pd <= 20000) ? pd * 2 + 50 : 65535;
      phase_items = $urandom_range(60, 140);
      for (i = 0; i < phase_items; i++) begin
        if (seg_left <= 0) begin
          bias = load_bias_t'($urandom_range(0, 3));
          seg_left = $urandom_range(8, 40);
        end
        seg_left--;
        case (bias)
          LD_HIGH: load_v = $urandom_range(tg, 65535);
          LD_LOW:  load_v = $urandom_range(0, tg);
          LD_NEAR: begin
            load_v = tg + $urandom_range(0, 8) - 4;
            if (load_v < 0) load_v = 0;
            if (load_v > 65535) load_v = 65535;
          end
          default: load_v = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 9))
          0:       delta_v = 0;
          1:       delta_v = 65535;
          2:       delta_v = $urandom_range(0, 65535);
          default: delta_v = $urandom_range(0, span);
        endcase
        add_tick(load_v, delta_v);
      end
      fed += phase_items;
      wait_drained();
    end

    // Let any stray beat show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
